// ===== hdl/evdf_pkg.sv =====
// evdf_pkg: shared types and constants of the echo vote distance filter
// used by evdf_sdiv, evdf_ctrl and echo_vote_distance_filter; no dependencies
package evdf_pkg;

    // default group length and field widths
    localparam int NUM_READINGS_DEF = 3;
    localparam int ECHO_W           = 16;
    localparam int THR_W            = 10;
    localparam int MIN_NEAR_W       = 2;
    localparam int CM_W             = 11;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 10;
    localparam int TDATA_IN_W       = 16;
    localparam int TDATA_OUT_W      = 16;

    // largest distance in cm a single reading can give: floor(65535 * 17 / 1000)
    localparam int CM_MAX = 1114;

    // serial divider: dividend, divisor and quotient widths
    // quotient is known to stay below 2**DIV_QW for both uses
    localparam int DIV_DW = 21;
    localparam int DIV_VW = 10;
    localparam int DIV_QW = 11;

    // us to cm: multiply by 17, divide by 1000
    localparam logic [DIV_VW-1:0] CM_DEN = DIV_VW'(1000);

    // reset values of the configuration registers
    localparam logic [THR_W-1:0]      THRESHOLD_RST = THR_W'(150);
    localparam logic [MIN_NEAR_W-1:0] MIN_NEAR_RST  = MIN_NEAR_W'(2);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_MIN_NEAR  = 1'b1
    } t_cfg_reg;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quot;
    } t_div_rsp;

    // group result handed to the output stage
    typedef struct packed {
        logic            valid;
        logic            obstacle;
        logic [CM_W-1:0] distance_cm;
    } t_result;

endpackage

// ===== hdl/evdf_sdiv.sv =====
// evdf_sdiv: restoring divider, one quotient bit per cycle
// depends on evdf_pkg (t_div_req, t_div_rsp, widths)
module evdf_sdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  evdf_pkg::t_div_req i_req,
    output evdf_pkg::t_div_rsp o_rsp
);

    localparam int DW = evdf_pkg::DIV_DW;
    localparam int VW = evdf_pkg::DIV_VW;
    localparam int QW = evdf_pkg::DIV_QW;
    localparam int CNTW = $clog2(QW + 1);

    logic [VW-1:0]   r_rem;
    logic [QW-1:0]   r_low;
    logic [QW-1:0]   r_quot;
    logic [VW-1:0]   r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [VW:0]     n_trial;
    logic            n_qbit;
    logic [VW:0]     n_diff;

    // trial subtract of the next dividend bit
    always_comb begin
        n_trial = {r_rem, r_low[QW-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_qbit  = (n_trial >= {1'b0, r_div});
    end

    // shift registers and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.dividend[DW-1:QW];
                r_low  <= i_req.dividend[QW-1:0];
                r_div  <= i_req.divisor;
                r_cnt  <= CNTW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= n_qbit ? n_diff[VW-1:0] : n_trial[VW-1:0];
                r_low  <= {r_low[QW-2:0], 1'b0};
                r_quot <= {r_quot[QW-2:0], n_qbit};
                r_cnt  <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== hdl/evdf_ctrl.sv =====
// evdf_ctrl: sequencer with near/far accumulators and the group vote
// depends on evdf_pkg; drives one shared evdf_sdiv through t_div_req
module evdf_ctrl #(
    parameter int NUM_READINGS = evdf_pkg::NUM_READINGS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [evdf_pkg::ECHO_W-1:0]         i_echo_us,
    input  logic [evdf_pkg::THR_W-1:0]          i_threshold_cm,
    input  logic [evdf_pkg::MIN_NEAR_W-1:0]     i_min_near,
    input  logic                                i_res_ready,
    output evdf_pkg::t_result                   o_res,
    output evdf_pkg::t_div_req                  o_div_req,
    input  evdf_pkg::t_div_rsp                  i_div_rsp
);

    localparam int CW = $clog2(NUM_READINGS + 1);
    localparam int SW = $clog2(NUM_READINGS * evdf_pkg::CM_MAX + 1);
    localparam int MW = (CW > evdf_pkg::MIN_NEAR_W) ? CW : evdf_pkg::MIN_NEAR_W;
    localparam int DW = evdf_pkg::DIV_DW;
    localparam int VW = evdf_pkg::DIV_VW;
    localparam int CM_W = evdf_pkg::CM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PICK,
        S_MEAN,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_slot;
    logic [CW-1:0]   r_near_cnt;
    logic [SW-1:0]   r_near_sum;
    logic [SW-1:0]   r_far_sum;
    logic            r_flag;
    logic [CM_W-1:0] r_dist;

    logic            n_near;
    logic            n_flag;
    logic [CW-1:0]   n_cnt;
    logic [SW-1:0]   n_sum;

    // near test of the converted reading, and the group vote
    always_comb begin
        n_near = (i_div_rsp.quot <= {1'b0, i_threshold_cm});
        n_flag = (MW'(r_near_cnt) >= MW'(i_min_near));
        n_cnt  = n_flag ? r_near_cnt : (CW'(NUM_READINGS) - r_near_cnt);
        n_sum  = n_flag ? r_near_sum : r_far_sum;
    end

    // divider requests: us * 17 / 1000 per item, sum / count per group
    always_comb begin
        o_div_req = '0;
        if (r_state == S_IDLE && i_in_valid) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = DW'({i_echo_us, 4'b0000}) + DW'(i_echo_us);
            o_div_req.divisor  = evdf_pkg::CM_DEN;
        end else if (r_state == S_PICK && n_cnt != '0) begin
            o_div_req.start    = 1'b1;
            o_div_req.dividend = DW'(n_sum);
            o_div_req.divisor  = VW'(n_cnt);
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_res.valid       = (r_state == S_EMIT);
    assign o_res.obstacle    = r_flag;
    assign o_res.distance_cm = r_dist;

    // sequencer, accumulators and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot     <= '0;
            r_near_cnt <= '0;
            r_near_sum <= '0;
            r_far_sum  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (i_div_rsp.done) begin
                        if (n_near) begin
                            r_near_cnt <= r_near_cnt + CW'(1);
                            r_near_sum <= r_near_sum + SW'(i_div_rsp.quot);
                        end else begin
                            r_far_sum  <= r_far_sum + SW'(i_div_rsp.quot);
                        end
                        if (r_slot == CW'(NUM_READINGS - 1)) begin
                            r_slot  <= '0;
                            r_state <= S_PICK;
                        end else begin
                            r_slot  <= r_slot + CW'(1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PICK: begin
                    r_flag <= n_flag;
                    if (n_cnt == '0) begin
                        // empty winning class
                        r_dist  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (i_div_rsp.done) begin
                        r_dist  <= i_div_rsp.quot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_res_ready) begin
                        r_near_cnt <= '0;
                        r_near_sum <= '0;
                        r_far_sum  <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/echo_vote_distance_filter.sv =====
// echo_vote_distance_filter: top level with config registers and output register
// depends on evdf_pkg, evdf_sdiv and evdf_ctrl
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------
//  s_axis    | in        | tvalid / tready         | tdata[15:0] echo_us
//  m_axis    | out       | tvalid / tready         | tdata[0] obstacle, [11:1] distance_cm
//  cfg       | in        | i_cfg_we, no wait       | i_cfg_index, i_cfg_data[9:0]
//
// each item is accepted and converted before the next is taken: the shared
// divider produces one quotient bit per cycle (11 bits)
// the last item of a group is followed by the mean divide and the hand-off
// reset is synchronous, active low; it clears group state and loads the
// default threshold and min_near
// a result waits in the output register; the next group's items are taken
// meanwhile, and the block holds only when a new result finds it still full
module echo_vote_distance_filter #(
    parameter int NUM_READINGS = evdf_pkg::NUM_READINGS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [evdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [evdf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input item stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [evdf_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // [15:0] echo_us
    // result item stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [evdf_pkg::TDATA_OUT_W-1:0]     m_axis_tdata   // [0] obstacle,
                                                                // [11:1] distance_cm
);

    logic [evdf_pkg::THR_W-1:0]       r_threshold_cm;
    logic [evdf_pkg::MIN_NEAR_W-1:0]  r_min_near;
    logic                             r_m_valid;
    logic [evdf_pkg::TDATA_OUT_W-1:0] r_m_data;

    evdf_pkg::t_div_req  w_div_req;
    evdf_pkg::t_div_rsp  w_div_rsp;
    evdf_pkg::t_result   w_res;
    logic                w_res_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_cm <= evdf_pkg::THRESHOLD_RST;
            r_min_near     <= evdf_pkg::MIN_NEAR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == evdf_pkg::REG_THRESHOLD) begin
                r_threshold_cm <= i_cfg_data[evdf_pkg::THR_W-1:0];
            end else if (i_cfg_index == evdf_pkg::REG_MIN_NEAR) begin
                r_min_near <= i_cfg_data[evdf_pkg::MIN_NEAR_W-1:0];
            end
        end
    end

    // sequencer and shared serial divider
    evdf_ctrl #(
        .NUM_READINGS (NUM_READINGS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_echo_us      (s_axis_tdata[evdf_pkg::ECHO_W-1:0]),
        .i_threshold_cm (r_threshold_cm),
        .i_min_near     (r_min_near),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res),
        .o_div_req      (w_div_req),
        .i_div_rsp      (w_div_rsp)
    );

    evdf_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // output register
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res.valid;
            if (w_res.valid) begin
                r_m_data <= evdf_pkg::TDATA_OUT_W'({w_res.distance_cm, w_res.obstacle});
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== tb/echo_vote_distance_filter_test.sv =====
// echo_vote_distance_filter_test: self-checking bench for the echo vote distance filter
// depends on evdf_pkg and echo_vote_distance_filter; predicts each group vote and
// checks it against the result stream, with and without random stalls on both sides
`timescale 1ns / 1ps

module echo_vote_distance_filter_test;

    localparam int GROUP_LEN      = evdf_pkg::NUM_READINGS_DEF;
    localparam int CM_PER_US_NUM  = 17;
    localparam int CM_PER_US_DEN  = 1000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int RAND_PHASES    = 9;
    localparam int ITEMS_PER_RUN  = 105;

    // one expected group vote
    typedef struct packed {
        logic                      obstacle;
        logic [evdf_pkg::CM_W-1:0] distance_cm;
    } t_vote;

    // rows of the directed table
    typedef enum logic {ROW_ECHO, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [evdf_pkg::ECHO_W-1:0]     echo_us;
        evdf_pkg::t_cfg_reg              reg_idx;
        logic [evdf_pkg::CFG_DATA_W-1:0] reg_val;
        bit                              typed;
        t_vote                           vote;
    } t_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [evdf_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [evdf_pkg::CFG_DATA_W-1:0]    i_cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [evdf_pkg::TDATA_IN_W-1:0]    s_axis_tdata;    // [15:0] echo_us
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [evdf_pkg::TDATA_OUT_W-1:0]   m_axis_tdata;    // [0] obstacle, [11:1] distance_cm

    // predictor copy of the registers and of the group accumulators
    logic [evdf_pkg::THR_W-1:0]         thr_reg;
    logic [evdf_pkg::MIN_NEAR_W-1:0]    min_near_reg;
    logic [3:0]                         slot_pos;
    logic [3:0]                         near_n;
    logic [14:0]                        near_acc;
    logic [14:0]                        far_acc;

    t_vote                   pending_votes[$];
    t_row                    directed_rows[$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_errors;
    int n_items;
    int n_votes;
    int n_writes;

    echo_vote_distance_filter #(
        .NUM_READINGS(GROUP_LEN)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // fold one reading into the group; returns 1 and the vote when the group closes
    function automatic bit fold_reading(input logic [evdf_pkg::ECHO_W-1:0] echo_us,
                                        output t_vote vote);
        logic [31:0] cm;
        logic [3:0]  far_n;
        logic [3:0]  cnt;
        logic [14:0] acc;
        cm   = (32'(echo_us) * CM_PER_US_NUM) / CM_PER_US_DEN;
        vote = '0;
        if (cm <= 32'(thr_reg)) begin
            near_n   = near_n + 4'd1;
            near_acc = near_acc + cm[14:0];
        end else begin
            far_acc = far_acc + cm[14:0];
        end
        slot_pos = slot_pos + 4'd1;
        if (slot_pos < 4'(GROUP_LEN))
            return 1'b0;
        // vote and mean of the winning class, empty class gives zero
        far_n         = 4'(GROUP_LEN) - near_n;
        vote.obstacle = (near_n >= 4'(min_near_reg));
        cnt           = vote.obstacle ? near_n : far_n;
        acc           = vote.obstacle ? near_acc : far_acc;
        vote.distance_cm = (cnt != 4'd0) ? evdf_pkg::CM_W'(acc / 15'(cnt)) : '0;
        slot_pos = '0;
        near_n   = '0;
        near_acc = '0;
        far_acc  = '0;
        return 1'b1;
    endfunction

    // random echo, weighted toward the near/far boundary of the current threshold
    function automatic logic [evdf_pkg::ECHO_W-1:0] pick_echo();
        int edge_us;
        edge_us = (int'(thr_reg) * CM_PER_US_DEN) / CM_PER_US_NUM
                  + int'($urandom_range(240)) - 120;
        if (edge_us < 0)
            edge_us = 0;
        if (edge_us > 65535)
            edge_us = 65535;
        unique case ($urandom_range(7))
            0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2:    return 16'($urandom_range(65535));
            3, 4, 5: return 16'(edge_us);
            6:       return 16'($urandom_range(3000));
            default: return 16'($urandom_range(65535, 60000));
        endcase
    endfunction

    function automatic void add_echo(input logic [evdf_pkg::ECHO_W-1:0] echo_us,
                                     input bit typed,
                                     input logic obstacle, input int distance_cm);
        t_row row;
        row.kind    = ROW_ECHO;
        row.echo_us = echo_us;
        row.reg_idx = evdf_pkg::REG_THRESHOLD;
        row.reg_val = '0;
        row.typed   = typed;
        row.vote    = {obstacle, evdf_pkg::CM_W'(distance_cm)};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input evdf_pkg::t_cfg_reg reg_idx,
                                    input logic [evdf_pkg::CFG_DATA_W-1:0] reg_val);
        t_row row;
        row.kind    = ROW_REG;
        row.echo_us = '0;
        row.reg_idx = reg_idx;
        row.reg_val = reg_val;
        row.typed   = 1'b0;
        row.vote    = '0;
        directed_rows.push_back(row);
    endfunction

    // offer one item, predict on acceptance; called and returns at a falling edge
    task automatic send_echo(input logic [evdf_pkg::ECHO_W-1:0] echo_us, input bit typed,
                             input t_vote typed_vote);
        t_vote vote;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = echo_us;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (fold_reading(echo_us, vote))
            pending_votes.push_back(typed ? typed_vote : vote);
        n_items++;
        @(negedge i_clk);
    endtask

    // wait until every vote came back and the block has gone quiet
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_votes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input evdf_pkg::t_cfg_reg reg_idx,
                             input logic [evdf_pkg::CFG_DATA_W-1:0] reg_val);
        i_cfg_we    = 1'b1;
        i_cfg_index = reg_idx;
        i_cfg_data  = reg_val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        unique case (reg_idx)
            evdf_pkg::REG_THRESHOLD: thr_reg      = reg_val[evdf_pkg::THR_W-1:0];
            evdf_pkg::REG_MIN_NEAR:  min_near_reg = reg_val[evdf_pkg::MIN_NEAR_W-1:0];
            default: ;
        endcase
        n_writes++;
    endtask

    // receiver stalls
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge i_clk) begin : check_votes
        t_vote want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_votes.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_votes.pop_front();
                n_votes++;
                if (m_axis_tdata[0] !== want.obstacle) begin
                    $display("%0t: obstacle mismatch, expected %0d, actual %0d",
                             $time, want.obstacle, m_axis_tdata[0]);
                    n_errors++;
                end
                if (m_axis_tdata[11:1] !== want.distance_cm) begin
                    $display("%0t: distance_cm mismatch, expected %0d, actual %0d",
                             $time, want.distance_cm, m_axis_tdata[11:1]);
                    n_errors++;
                end
                if (m_axis_tdata[15:12] !== 4'h0) begin
                    $display("%0t: tdata padding mismatch, expected 0, actual %h",
                             $time, m_axis_tdata[15:12]);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("echo_vote_distance_filter test failed");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        t_row                            row;
        logic [evdf_pkg::THR_W-1:0]      thr_plan[RAND_PHASES];
        logic [evdf_pkg::MIN_NEAR_W-1:0] min_plan[RAND_PHASES];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = evdf_pkg::REG_THRESHOLD;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        send_idle_pct = 36;
        recv_idle_pct = 55;
        n_errors      = 0;
        n_items       = 0;
        n_votes       = 0;
        n_writes      = 0;
        thr_reg       = evdf_pkg::THRESHOLD_RST;
        min_near_reg  = evdf_pkg::MIN_NEAR_RST;
        slot_pos      = '0;
        near_n        = '0;
        near_acc      = '0;
        far_acc       = '0;

        // reset defaults: threshold 150, min_near 2
        add_echo(16'd0, 0, 0, 0);
        add_echo(16'd0, 0, 0, 0);
        add_echo(16'd0, 1, 1, 0);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'hFFFF, 1, 0, 1114);
        // 8882 us is 150 cm, 8883 us is 151 cm
        add_echo(16'd8882, 0, 0, 0);
        add_echo(16'd8883, 0, 0, 0);
        add_echo(16'd8882, 1, 1, 150);
        add_echo(16'd8883, 0, 0, 0);
        add_echo(16'd8883, 0, 0, 0);
        add_echo(16'd0, 1, 0, 151);
        // min_near zero, upper data bits masked off; near class empty gives zero
        add_reg(evdf_pkg::REG_THRESHOLD, 10'd0);
        add_reg(evdf_pkg::REG_MIN_NEAR, 10'h3FC);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'd100, 1, 1, 0);
        add_echo(16'd58, 0, 0, 0);
        add_echo(16'd59, 0, 0, 0);
        add_echo(16'hFFFF, 0, 0, 0);
        // top threshold, all three needed; 60235 us is 1023 cm
        add_reg(evdf_pkg::REG_THRESHOLD, 10'd1023);
        add_reg(evdf_pkg::REG_MIN_NEAR, 10'd3);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'hFFFF, 0, 0, 0);
        add_echo(16'hFFFF, 1, 0, 1114);
        add_echo(16'd60235, 0, 0, 0);
        add_echo(16'd60236, 0, 0, 0);
        add_echo(16'd60235, 0, 0, 0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_echo(row.echo_us, row.typed, row.vote);
            end
        end

        // random phases, register settings with the extremes first
        thr_plan = '{10'd0, 10'd1023, 10'd150, 10'($urandom_range(1023)), 10'd1023,
                     10'd0, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                     10'($urandom_range(1023))};
        min_plan = '{2'd0, 2'd3, 2'd1, 2'd2, 2'($urandom_range(3)), 2'd3, 2'd0, 2'd1,
                     2'($urandom_range(3))};
        for (int p = 0; p < RAND_PHASES; p++) begin
            unique case (p / 3)
                0: begin send_idle_pct = 36; recv_idle_pct = 55; end
                1: begin send_idle_pct = 55; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            drain();
            write_reg(evdf_pkg::REG_THRESHOLD, thr_plan[p]);
            write_reg(evdf_pkg::REG_MIN_NEAR, {8'($urandom_range(255)), min_plan[p]});
            for (int n = 0; n < ITEMS_PER_RUN; n++)
                send_echo(pick_echo(), 1'b0, '0);
        end

        drain();
        $display("covered %0d echo items, %0d group votes and %0d register writes,",
                 n_items, n_votes, n_writes);
        $display("thresholds 0 to 1023, min_near 0 to 3, stalls on both sides and none");
        if (n_errors == 0 && pending_votes.size() == 0) begin
            $display("echo_vote_distance_filter test passed");
        end else begin
            $display("echo_vote_distance_filter test failed");
        end
        $finish;
    end

endmodule
